FILE: sv/aat_pkg.sv
package aat_pkg;

    localparam int MAX_NUMBER_CHARS_DEF = 8;
    localparam int KEYWORD_COUNT_DEF    = 45;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam int KW_TABLE_SIZE = 45;
    localparam int WORD_KEEP     = 4;

    typedef enum logic [2:0] {
        K_COMMA   = 3'd0,
        K_HASH    = 3'd1,
        K_NUMBER  = 3'd2,
        K_KEYWORD = 3'd3,
        K_INVALID = 3'd4,
        K_EOL     = 3'd5,
        K_EOI     = 3'd6
    } t_kind;

    // sorted mnemonic and register table, packed ASCII, first char in top used byte
    localparam logic [31:0] KW_CHARS [KW_TABLE_SIZE] = '{
        "adc", "add", "and", "ands", "asl", "asr", "bic", "cmn", "cmp",
        "eor", "fp", "ip", "lr", "lsl", "lsr", "mov", "mvn", "orr", "pc",
        "r0", "r1", "r10", "r11", "r12", "r13", "r14", "r15", "r2", "r3",
        "r4", "r5", "r6", "r7", "r8", "r9", "ror", "rrx", "rsb", "rsc",
        "sbc", "sl", "sp", "sub", "teq", "tst"
    };

    // one scanner event: an optional finished word or number, then an optional
    // single-byte token at the current position
    typedef struct packed {
        logic        has_pend;
        logic        pend_word;
        logic [63:0] pend_text;
        logic [3:0]  pend_len;
        logic        pend_ovf;
        logic [15:0] pend_line;
        logic [15:0] pend_col;
        logic        has_simple;
        t_kind       simple_kind;
        logic [15:0] cur_line;
        logic [15:0] cur_col;
    } t_evt;

endpackage

FILE: sv/aat_if.sv
interface aat_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source(output valid, output char_in, output end_of_input, input ready);
    modport sink(input valid, input char_in, input end_of_input, output ready);
endinterface

interface aat_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [5:0]  keyword_index;
    logic [63:0] number_text;
    logic [3:0]  number_length;
    logic        number_overflow;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last_of_run;

    modport source(
        output valid, output token_kind, output keyword_index, output number_text,
        output number_length, output number_overflow, output token_line,
        output token_column, output last_of_run, input ready
    );
    modport sink(
        input valid, input token_kind, input keyword_index, input number_text,
        input number_length, input number_overflow, input token_line,
        input token_column, input last_of_run, output ready
    );
endinterface

FILE: sv/arm_asm_tokenizer.sv
// Streaming tokenizer for ARM assembly text.
// Input channel i_byte: one source byte per transaction (char_in), or an
// end-of-input mark (end_of_input = 1, char_in ignored).
// Output channel o_tok: one token per transaction with kind, keyword index,
// number text, line and column of its first byte, and last_of_run set on the
// final token caused by one input transaction.
// A byte is accepted every cycle while the event queue has room. A byte that
// ends a word or number and is itself a token gives two tokens; the output
// stage emits both from that byte's single queue event, one after the other,
// and pops the event only together with the second token.
// The scanner writes each event into the queue, and the match stage
// registers the token from the queue head into the o_tok output register.
// The keyword lookup is a combinational parallel compare over the table.
// When o_tok.ready is low, the output register holds and the queue fills
// (QUEUE_DEPTH events); i_byte.ready drops only when the queue is full.
// Reset (synchronous, active low) empties queue and output stage, returns the
// scanner to idle and sets line and column to one.
module arm_asm_tokenizer
    import aat_pkg::*;
#(
    parameter int MAX_NUMBER_CHARS = MAX_NUMBER_CHARS_DEF,
    parameter int KEYWORD_COUNT    = KEYWORD_COUNT_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aat_byte_if.sink  i_byte,
    aat_tok_if.source o_tok
);

    logic push, full, q_valid, pop;
    t_evt push_evt, head;

    aat_front #(
        .MAX_NUMBER_CHARS(MAX_NUMBER_CHARS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (i_byte),
        .i_full (full),
        .o_push (push),
        .o_evt  (push_evt)
    );

    aat_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_evt  (push_evt),
        .o_full (full),
        .o_valid(q_valid),
        .o_head (head),
        .i_pop  (pop)
    );

    aat_back #(
        .KEYWORD_COUNT(KEYWORD_COUNT)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_head (head),
        .o_pop  (pop),
        .o_tok  (o_tok)
    );

endmodule

FILE: sv/aat_front.sv
module aat_front
    import aat_pkg::*;
#(
    parameter int MAX_NUMBER_CHARS = MAX_NUMBER_CHARS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    aat_byte_if.sink i_byte,
    input  logic     i_full,
    output logic     o_push,
    output t_evt     o_evt
);

    typedef enum logic [1:0] {
        M_IDLE = 2'd0,
        M_WORD = 2'd1,
        M_NUM  = 2'd2
    } t_mode;

    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChX     = 8'h78;
    localparam logic [15:0] PosMax = 16'hFFFF;

    t_mode       r_mode, n_mode;
    logic [63:0] r_text, n_text;
    logic [3:0]  r_len, n_len;
    logic        r_spill, n_spill;
    logic [15:0] r_line, n_line;
    logic [15:0] r_col, n_col;
    logic [15:0] r_sline, n_sline;
    logic [15:0] r_scol, n_scol;

    logic       accept;
    logic [7:0] c;
    logic       is_digit, is_alnum, is_hexx, in_token;
    t_evt       evt;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign c            = i_byte.char_in;
    assign in_token     = (r_mode == M_WORD) || (r_mode == M_NUM);

    always_comb begin
        is_digit = (c >= "0") && (c <= "9");
        is_alnum = is_digit || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        is_hexx  = is_digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"))
                   || (c == ChX);
    end

    always_comb begin
        n_mode  = r_mode;
        n_text  = r_text;
        n_len   = r_len;
        n_spill = r_spill;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;

        evt             = '0;
        evt.pend_word   = (r_mode == M_WORD);
        evt.pend_text   = r_text;
        evt.pend_len    = r_len;
        evt.pend_ovf    = r_spill;
        evt.pend_line   = r_sline;
        evt.pend_col    = r_scol;
        evt.simple_kind = K_EOL;
        evt.cur_line    = r_line;
        evt.cur_col     = r_col;

        if (i_byte.end_of_input) begin
            evt.has_pend    = in_token;
            evt.has_simple  = 1'b1;
            evt.simple_kind = K_EOI;
            n_mode          = M_IDLE;
        end else begin
            if ((r_mode == M_WORD) && is_alnum) begin
                if (r_len < 4'(WORD_KEEP)) begin
                    n_text = {r_text[55:0], c};
                end
                if (r_len <= 4'(WORD_KEEP)) begin
                    n_len = r_len + 4'd1;
                end
            end else if ((r_mode == M_NUM) && is_hexx) begin
                if (r_len < 4'(MAX_NUMBER_CHARS)) begin
                    n_text = {r_text[55:0], c};
                    n_len  = r_len + 4'd1;
                end else begin
                    n_spill = 1'b1;
                end
            end else begin
                evt.has_pend = in_token;
                n_mode       = M_IDLE;
                if ((c == ChSpace) || (c == ChTab)) begin
                    evt.has_simple = 1'b0;
                end else if (c == ChComma) begin
                    evt.has_simple  = 1'b1;
                    evt.simple_kind = K_COMMA;
                end else if (c == ChHash) begin
                    evt.has_simple  = 1'b1;
                    evt.simple_kind = K_HASH;
                end else if ((c == ChNul) || (c == ChLf) || (c == ChCr)) begin
                    evt.has_simple  = 1'b1;
                    evt.simple_kind = K_EOL;
                end else begin
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_text  = {56'd0, c};
                    n_len   = 4'd1;
                    n_spill = 1'b0;
                    n_mode  = is_digit ? M_NUM : M_WORD;
                end
            end
            if (c == ChLf) begin
                if (r_line != PosMax) begin
                    n_line = r_line + 16'd1;
                end
                n_col = 16'd1;
            end else if (r_col != PosMax) begin
                n_col = r_col + 16'd1;
            end
        end
    end

    assign o_push = accept && (evt.has_pend || evt.has_simple);
    assign o_evt  = evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= 16'd1;
            r_col   <= 16'd1;
            r_sline <= 16'd1;
            r_scol  <= 16'd1;
            r_text  <= '0;
            r_len   <= '0;
            r_spill <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_text  <= n_text;
            r_len   <= n_len;
            r_spill <= n_spill;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
        end
    end

`ifndef SYNTHESIS
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_evt.has_pend || o_evt.has_simple))
        else $error("event pushed without a token");
    a_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_WORD) |-> ((r_len != 4'd0) && (r_len <= 4'(WORD_KEEP + 1))))
        else $error("word length out of range");
`endif

endmodule

FILE: sv/aat_queue.sv
module aat_queue
    import aat_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    output logic o_full,
    output logic o_valid,
    output t_evt o_head,
    input  logic i_pop
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_evt            r_mem [DEPTH];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PtrW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PtrW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && i_push) |-> do_pop)
        else $error("push into full queue");
`endif

endmodule

FILE: sv/aat_back.sv
module aat_back
    import aat_pkg::*;
#(
    parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_evt      i_head,
    output logic      o_pop,
    aat_tok_if.source o_tok
);

    localparam int KwN = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

    logic        r_valid;
    logic        r_phase;
    t_kind       r_kind;
    logic [5:0]  r_idx;
    logic [63:0] r_text;
    logic [3:0]  r_nlen;
    logic        r_ovf;
    logic [15:0] r_line, r_col;
    logic        r_last;

    logic       load, emit_pend;
    logic       kw_hit;
    logic [5:0] kw_idx;

    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = KwN - 1; i >= 0; i--) begin
            if (i_head.pend_text[31:0] == KW_CHARS[i]) begin
                kw_hit = 1'b1;
                kw_idx = 6'(i);
            end
        end
        if (i_head.pend_len > 4'(WORD_KEEP)) begin
            kw_hit = 1'b0;
        end
    end

    assign load      = i_valid && (!r_valid || o_tok.ready);
    assign emit_pend = i_head.has_pend && !r_phase;
    assign o_pop     = load && !(emit_pend && i_head.has_simple);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= emit_pend && i_head.has_simple;
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_pend) begin
                r_line <= i_head.pend_line;
                r_col  <= i_head.pend_col;
                r_last <= !i_head.has_simple;
                if (i_head.pend_word) begin
                    r_kind <= kw_hit ? K_KEYWORD : K_INVALID;
                    r_idx  <= kw_hit ? kw_idx : 6'd0;
                    r_text <= '0;
                    r_nlen <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_kind <= K_NUMBER;
                    r_idx  <= '0;
                    r_text <= i_head.pend_text;
                    r_nlen <= i_head.pend_len;
                    r_ovf  <= i_head.pend_ovf;
                end
            end else begin
                r_kind <= i_head.simple_kind;
                r_idx  <= '0;
                r_text <= '0;
                r_nlen <= '0;
                r_ovf  <= 1'b0;
                r_line <= i_head.cur_line;
                r_col  <= i_head.cur_col;
                r_last <= 1'b1;
            end
        end
    end

    assign o_tok.valid           = r_valid;
    assign o_tok.token_kind      = r_kind;
    assign o_tok.keyword_index   = r_idx;
    assign o_tok.number_text     = r_text;
    assign o_tok.number_length   = r_nlen;
    assign o_tok.number_overflow = r_ovf;
    assign o_tok.token_line      = r_line;
    assign o_tok.token_column    = r_col;
    assign o_tok.last_of_run     = r_last;

`ifndef SYNTHESIS
    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_valid && i_head.has_pend && i_head.has_simple))
        else $error("second half of event lost its queue entry");
`endif

endmodule
